[src/gaussian_prime_sieve_step_defines.svh]
// Assertion helpers for the sieve block; clocked on clk_i, off during reset.
`ifndef GAUSSIAN_PRIME_SIEVE_STEP_DEFINES_SVH
`define GAUSSIAN_PRIME_SIEVE_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define GPS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define GPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPS_ASSERT(lbl, ante, cons, msg)
`define GPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[src/gps_pkg.sv]
`default_nettype none
package gps_pkg;

  localparam int unsigned GridSideDef = 256;
  localparam int unsigned CoordW      = 8;
  localparam logic [CoordW-1:0] RadiusRst = 8'd200;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ZSQ,
    S_ROOT,
    S_MAGCHK,
    S_ZRD,
    S_ZCHK,
    S_DIV,
    S_VRD,
    S_VCHK,
    S_MUL,
    S_BND,
    S_SQ,
    S_CMP,
    S_NEXT
  } state_e;

endpackage
`default_nettype wire

[src/gaussian_prime_sieve_step.sv]
// Gaussian prime sieve step. Each input word is a first-quadrant candidate
// (cand_re, cand_im) and a ring bound; a newly reached candidate under the
// radius comes out as one output word, otherwise none. After reset the block
// clears its GRID_SIDE*GRID_SIDE bitmap, one bit a cycle, before taking any
// input; the radius register may be written then. A candidate at or beyond
// the radius ends after the magnitude work. Otherwise magnitude, bitmap check
// and division follow (the zero candidate skips the division), then each
// multiplier of the sweep is read from the bitmap and, when already reached,
// multiplied and checked against the radius; the sweep covers (limit+1)^2
// multipliers, and the block returns to idle before taking the next word.
// All arithmetic runs through one 8x8 multiplier and a shift/subtract step
// under a sequencer, and the single-port bitmap access sets the floor.
`default_nettype none
`include "gaussian_prime_sieve_step_defines.svh"
module gaussian_prime_sieve_step #(
  parameter int unsigned GRID_SIDE = gps_pkg::GridSideDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [gps_pkg::CoordW-1:0] radius_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [gps_pkg::CoordW-1:0] cand_re_i,
  input  wire logic [gps_pkg::CoordW-1:0] cand_im_i,
  input  wire logic [gps_pkg::CoordW-1:0] ring_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [gps_pkg::CoordW-1:0]      prime_re_o,
  output logic [gps_pkg::CoordW-1:0]      prime_im_o
);
  import gps_pkg::*;

  localparam int unsigned Depth = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(Depth);

  function automatic logic in_grid(input logic [CoordW-1:0] c);
    return 32'(c) < GRID_SIDE;
  endfunction

  function automatic logic [AW-1:0] cell_idx(input logic [CoordW-1:0] x,
                                             input logic [CoordW-1:0] y);
    return AW'(32'(x) + GRID_SIDE * 32'(y));
  endfunction

  state_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CoordW-1:0] radius_q, radius_d;
  logic [CoordW-1:0] zr_q, zr_d, zi_q, zi_d, lim_q, lim_d;
  logic [17:0] v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic [8:0]  rem_q, rem_d;
  logic [CoordW-1:0] quo_q, quo_d, dvd_q, dvd_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d, k_q, k_d;
  logic        phb_q, phb_d;
  logic signed [18:0] cr_q, cr_d, ci_q, ci_d;
  logic [CoordW-1:0] acr_q, acr_d;
  logic [16:0] sum_q, sum_d;
  logic [15:0] rsq_q, rsq_d;
  logic        out_valid_q, out_valid_d;
  logic [CoordW-1:0] pre_q, pre_d, pim_q, pim_d;

  logic        mem [Depth];
  logic        rd_q;
  logic        rd_en, wr_en, wr_dat;
  logic [AW-1:0] rd_addr, wr_addr;

  logic [CoordW-1:0] mul_a, mul_b;
  logic [15:0] mul_p;
  logic [8:0]  mag;
  logic [17:0] root_t;
  logic [8:0]  rem_n;
  logic        z_hit, b_hit, bnd_ok, ring_end, sweep_last;
  logic signed [18:0] rad_s;
  logic [CoordW-1:0] tx, ty;

  assign mag    = r_q[8:0];
  assign root_t = r_q + bit_q;
  assign rem_n  = {rem_q[7:0], dvd_q[CoordW-1]};
  assign rad_s  = $signed({11'b0, radius_q});
  assign z_hit  = in_grid(zr_q) && in_grid(zi_q) && rd_q;
  assign b_hit  = in_grid(x_q) && in_grid(y_q) && rd_q;
  assign bnd_ok = (ci_q < rad_s) && (cr_q < rad_s) && (cr_q > -rad_s);
  assign ring_end   = phb_q ? (x_q == '0) : ((y_q == k_q) && (k_q == '0));
  assign sweep_last = ring_end && (k_q == lim_q);
  assign tx = cr_q[18] ? ci_q[CoordW-1:0] : cr_q[CoordW-1:0];
  assign ty = cr_q[18] ? acr_q : ci_q[CoordW-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = zr_q;
    mul_b = zr_q;
    case (state_q)
      S_ZSQ: begin
        if (step_q[0]) begin
          mul_a = zi_q;
          mul_b = zi_q;
        end
      end
      S_MUL: begin
        case (step_q[1:0])
          2'd0: begin mul_a = zr_q; mul_b = x_q; end
          2'd1: begin mul_a = zi_q; mul_b = y_q; end
          2'd2: begin mul_a = zr_q; mul_b = y_q; end
          default: begin mul_a = zi_q; mul_b = x_q; end
        endcase
      end
      S_SQ: begin
        case (step_q[1:0])
          2'd0: begin mul_a = acr_q; mul_b = acr_q; end
          2'd1: begin mul_a = ci_q[CoordW-1:0]; mul_b = ci_q[CoordW-1:0]; end
          default: begin mul_a = radius_q; mul_b = radius_q; end
        endcase
      end
      default: ;
    endcase
  end
  assign mul_p = 16'(mul_a) * 16'(mul_b);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i && in_ready_o) state_d = S_ZSQ;
      S_ZSQ:    if (step_q == 4'd1) state_d = S_ROOT;
      S_ROOT:   if (step_q == 4'd8) state_d = S_MAGCHK;
      S_MAGCHK: state_d = ({1'b0, radius_q} <= mag) ? S_IDLE : S_ZRD;
      S_ZRD:    state_d = S_ZCHK;
      S_ZCHK:   state_d = (zr_q == '0 && zi_q == '0) ? S_VRD : S_DIV;
      S_DIV:    if (step_q == 4'd7) state_d = S_VRD;
      S_VRD:    state_d = S_VCHK;
      S_VCHK:   state_d = b_hit ? S_MUL : S_NEXT;
      S_MUL:    if (step_q == 4'd3) state_d = S_BND;
      S_BND:    state_d = bnd_ok ? S_SQ : S_NEXT;
      S_SQ:     if (step_q == 4'd2) state_d = S_CMP;
      S_CMP:    state_d = S_NEXT;
      S_NEXT:   state_d = sweep_last ? S_IDLE : S_VRD;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    step_d = (state_d != state_q) ? 4'd0 : step_q + 4'd1;
    clr_d = clr_q;
    radius_d = radius_q;
    zr_d = zr_q; zi_d = zi_q; lim_d = lim_q;
    v_d = v_q; r_d = r_q; bit_d = bit_q;
    rem_d = rem_q; quo_d = quo_q; dvd_d = dvd_q;
    x_d = x_q; y_d = y_q; k_d = k_q; phb_d = phb_q;
    cr_d = cr_q; ci_d = ci_q; acr_d = acr_q;
    sum_d = sum_q; rsq_d = rsq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pre_d = pre_q; pim_d = pim_q;
    rd_en = 1'b0; rd_addr = cell_idx(zr_q, zi_q);
    wr_en = 1'b0; wr_addr = cell_idx(zr_q, zi_q); wr_dat = 1'b1;

    if (cfg_valid_i) radius_d = radius_i;

    case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_q; wr_dat = 1'b0;
        clr_d = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          zr_d = cand_re_i; zi_d = cand_im_i; lim_d = ring_i;
        end
      end
      S_ZSQ: begin
        if (step_q[0]) v_d = v_q + 18'(mul_p);
        else           v_d = 18'(mul_p);
        r_d = '0;
        bit_d = 18'h10000;
      end
      S_ROOT: begin
        if (v_q >= root_t) begin
          v_d = v_q - root_t;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      S_MAGCHK: begin
        rd_en = 1'b1;
        rem_d = '0; quo_d = '0; dvd_d = radius_q;
      end
      S_ZCHK: begin
        x_d = '0; y_d = '0; k_d = '0; phb_d = 1'b0;
        if (!z_hit) begin
          wr_en = in_grid(zr_q) && in_grid(zi_q);
          out_valid_d = 1'b1;
          pre_d = zr_q; pim_d = zi_q;
        end
      end
      S_DIV: begin
        dvd_d = dvd_q << 1;
        if (rem_n >= mag) begin
          rem_d = rem_n - mag;
          quo_d = {quo_q[CoordW-2:0], 1'b1};
        end else begin
          rem_d = rem_n;
          quo_d = {quo_q[CoordW-2:0], 1'b0};
        end
        if (step_q == 4'd7 && quo_d < lim_q) lim_d = quo_d;
      end
      S_VRD: begin
        rd_en = 1'b1; rd_addr = cell_idx(x_q, y_q);
      end
      S_MUL: begin
        case (step_q[1:0])
          2'd0: cr_d = $signed({3'b0, mul_p});
          2'd1: cr_d = cr_q - $signed({3'b0, mul_p});
          2'd2: ci_d = $signed({3'b0, mul_p});
          default: ci_d = ci_q + $signed({3'b0, mul_p});
        endcase
      end
      S_BND: begin
        acr_d = cr_q[18] ? CoordW'(-cr_q) : cr_q[CoordW-1:0];
      end
      S_SQ: begin
        case (step_q[1:0])
          2'd0: sum_d = 17'(mul_p);
          2'd1: sum_d = sum_q + 17'(mul_p);
          default: rsq_d = mul_p;
        endcase
      end
      S_CMP: begin
        wr_addr = cell_idx(tx, ty);
        wr_en = (sum_q < {1'b0, rsq_q}) && in_grid(tx) && in_grid(ty);
      end
      S_NEXT: begin
        // advance ring by ring: (k,0..k), then (k-1..0,k)
        if (ring_end) begin
          k_d = k_q + CoordW'(1); x_d = k_q + CoordW'(1); y_d = '0; phb_d = 1'b0;
        end else if (!phb_q) begin
          if (y_q != k_q) begin
            y_d = y_q + CoordW'(1);
          end else begin
            x_d = k_q - CoordW'(1); y_d = k_q; phb_d = 1'b1;
          end
        end else begin
          x_d = x_q - CoordW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      radius_q    <= RadiusRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      radius_q    <= radius_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q <= zr_d; zi_q <= zi_d; lim_q <= lim_d;
    v_q <= v_d; r_q <= r_d; bit_q <= bit_d;
    rem_q <= rem_d; quo_q <= quo_d; dvd_q <= dvd_d;
    x_q <= x_d; y_q <= y_d; k_q <= k_d; phb_q <= phb_d;
    cr_q <= cr_d; ci_q <= ci_d; acr_q <= acr_d;
    sum_q <= sum_d; rsq_q <= rsq_d;
    pre_q <= pre_d; pim_q <= pim_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_dat;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign prime_re_o  = pre_q;
  assign prime_im_o  = pim_q;

  `GPS_ASSERT(a_no_take_in_clear, state_q == S_CLEAR, !in_ready_o, "input taken during clear")
  `GPS_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_ZSQ, "accept lost")
  `GPS_ASSERT(a_emit_from_check, $rose(out_valid_o), $past(state_q) == S_ZCHK, "stray word")

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import gps_pkg::*;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t re;
    coord_t im;
  } prime_t;

  localparam int unsigned GridSide = GridSideDef;
  localparam int unsigned WatchLimit = 3000000;

  class sieve_scoreboard;
    bit     reached [GridSide*GridSide];
    coord_t radius;
    prime_t pending_primes[$];
    int     mismatches;

    function new();
      foreach (reached[i]) reached[i] = 1'b0;
      radius = RadiusRst;
      mismatches = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned mag_of(longint re, longint im);
      return int_sqrt(longint'(re * re) + longint'(im * im));
    endfunction

    function bit is_reached(longint x, longint y);
      if (x < 0 || y < 0 || x >= GridSide || y >= GridSide) return 1'b0;
      return reached[x + GridSide * y];
    endfunction

    function void mark(longint x, longint y);
      if (x < 0 || y < 0 || x >= GridSide || y >= GridSide) return;
      reached[x + GridSide * y] = 1'b1;
    endfunction

    // multiply z by a reached multiplier and mark the product, folded into the quadrant
    function void try_multiplier(longint zr, longint zi, longint x, longint y);
      longint cr;
      longint ci;
      longint rad;
      rad = longint'(radius);
      if (!is_reached(x, y)) return;
      cr = zr * x - zi * y;
      ci = zr * y + zi * x;
      if (ci < rad && cr < rad && mag_of(cr, ci) < rad) begin
        if (cr < 0) mark(ci, -cr);
        else mark(cr, ci);
      end
    endfunction

    // predict one accepted candidate; returns the sweep limit for timing estimates
    function int note_candidate(coord_t re, coord_t im, coord_t ring);
      longint unsigned m;
      int lim;
      int q;
      prime_t p;
      m = mag_of(longint'(re), longint'(im));
      if (m >= radius) return -1;
      if (!is_reached(longint'(re), longint'(im))) begin
        mark(longint'(re), longint'(im));
        p.re = re;
        p.im = im;
        pending_primes.push_back(p);
      end
      lim = int'(ring);
      if (re != 0 || im != 0) begin
        q = int'(radius) / int'(m);
        if (q < lim) lim = q;
      end
      for (int k = 0; k <= lim; k++) begin
        for (int j = 0; j <= k; j++)
          try_multiplier(longint'(re), longint'(im), longint'(k), longint'(j));
        for (int j = k; j > 0; j--)
          try_multiplier(longint'(re), longint'(im), longint'(j - 1), longint'(k));
      end
      return lim;
    endfunction

    function void check_prime(coord_t re, coord_t im);
      prime_t exp_p;
      if (pending_primes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: re=%0d im=%0d", re, im);
        return;
      end
      exp_p = pending_primes.pop_front();
      if (exp_p.re !== re || exp_p.im !== im) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                   exp_p.re, exp_p.im, re, im);
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_valid_i;
  logic   cfg_ready_o;
  coord_t radius_i;
  logic   in_valid_i;
  logic   in_ready_o;
  coord_t cand_re_i;
  coord_t cand_im_i;
  coord_t ring_i;
  logic   out_valid_o;
  logic   out_ready_i;
  coord_t prime_re_o;
  coord_t prime_im_o;

  sieve_scoreboard primes_sb;
  int  quiet_cycles;
  int  out_stall;
  bit  steady_out;
  int  last_cost;

  gaussian_prime_sieve_step u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .radius_i    (radius_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cand_re_i   (cand_re_i),
    .cand_im_i   (cand_im_i),
    .ring_i      (ring_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .prime_re_o  (prime_re_o),
    .prime_im_o  (prime_im_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // output side: random stalls unless a steady stretch is on
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
    end else if (steady_out) begin
      out_ready_i <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) primes_sb.check_prime(prime_re_o, prime_im_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_radius(coord_t value);
    cfg_valid_i <= 1'b1;
    radius_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    primes_sb.radius = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold valid and payload until the word is taken
  task automatic send_candidate(coord_t re, coord_t im, coord_t ring);
    int lim;
    in_valid_i <= 1'b1;
    cand_re_i <= re;
    cand_im_i <= im;
    ring_i <= ring;
    do @(posedge clk_i); while (!in_ready_o);
    lim = primes_sb.note_candidate(re, im, ring);
    last_cost = (lim < 0) ? 60 : 60 + 16 * (lim + 1) * (lim + 1);
  endtask

  task automatic idle_gap(int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid, let every expected word arrive, then let the last sweep finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (primes_sb.pending_primes.size() != 0) @(posedge clk_i);
    repeat (2 * last_cost) @(posedge clk_i);
  endtask

  task automatic random_candidate();
    coord_t re;
    coord_t im;
    coord_t ring;
    int r;
    int span;
    span = int'(primes_sb.radius);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      re = coord_t'($urandom_range(0, span));
      im = coord_t'($urandom_range(0, span));
    end else if (r < 85) begin
      re = coord_t'($urandom_range(0, 12));
      im = coord_t'($urandom_range(0, 12));
    end else begin
      re = coord_t'($urandom_range(0, 255));
      im = coord_t'($urandom_range(0, 255));
    end
    r = $urandom_range(0, 99);
    if (r < 80) ring = coord_t'($urandom_range(0, 6));
    else if (r < 95) ring = coord_t'($urandom_range(7, 20));
    else ring = coord_t'($urandom_range(0, 255));
    // a zero candidate sweeps the full ring; keep it short
    if (re == 0 && im == 0 && ring > 20) ring = coord_t'($urandom_range(0, 20));
    send_candidate(re, im, ring);
  endtask

  initial begin
    coord_t phase_radius [6];
    primes_sb = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    radius_i = '0;
    in_valid_i = 1'b0;
    cand_re_i = '0;
    cand_im_i = '0;
    ring_i = '0;
    steady_out = 1'b0;
    last_cost = 60;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_radius(8'd200);

    // directed: zero and one, axes, edges of the radius, field extremes, repeats
    send_candidate(8'd0, 8'd0, 8'd0);
    send_candidate(8'd1, 8'd0, 8'd3);
    send_candidate(8'd0, 8'd1, 8'd3);
    send_candidate(8'd1, 8'd1, 8'd5);
    send_candidate(8'd2, 8'd1, 8'd4);
    send_candidate(8'd2, 8'd1, 8'd4);
    send_candidate(8'd1, 8'd2, 8'd4);
    send_candidate(8'd3, 8'd0, 8'd10);
    send_candidate(8'd255, 8'd255, 8'd255);
    send_candidate(8'd255, 8'd0, 8'd0);
    send_candidate(8'd0, 8'd255, 8'd1);
    send_candidate(8'd199, 8'd0, 8'd2);
    send_candidate(8'd200, 8'd0, 8'd2);
    send_candidate(8'd100, 8'd100, 8'd255);
    send_candidate(8'd140, 8'd140, 8'd2);
    send_candidate(8'd141, 8'd141, 8'd2);
    send_candidate(8'd142, 8'd141, 8'd1);
    send_candidate(8'd0, 8'd0, 8'd20);
    send_candidate(8'd5, 8'd2, 8'd12);
    send_candidate(8'd7, 8'd0, 8'd8);
    drain();

    phase_radius[0] = 8'd1;
    phase_radius[1] = 8'd255;
    phase_radius[2] = 8'd37;
    phase_radius[3] = coord_t'($urandom_range(2, 254));
    phase_radius[4] = 8'd128;
    phase_radius[5] = 8'd200;
    for (int ph = 0; ph < 6; ph++) begin
      write_radius(phase_radius[ph]);
      steady_out = (ph == 2);
      for (int n = 0; n < 98; n++) begin
        random_candidate();
        if (ph == 4) continue;
        idle_gap(pick_gap());
      end
      drain();
    end
    steady_out = 1'b0;

    if (primes_sb.mismatches == 0 && primes_sb.pending_primes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[gaussian_prime_sieve_step.f]
+incdir+src
src/gps_pkg.sv
src/gaussian_prime_sieve_step.sv
tb/testbench.sv
